@@ sv/rct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_pkg: shared types and constants of the resident credential table
// Action and status codes, the command and status groups that run between the
// controller and the datapath, and the default sizes of the table.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int SLOTS_DEF         = 16;
  localparam int USER_ID_BYTES_DEF = 64;
  localparam int KEY_WORDS         = 4;
  localparam int RESULT_CAP        = 16;

  typedef enum logic [2:0] {
    ACT_LOAD      = 3'd0,
    ACT_SAVE      = 3'd1,
    ACT_FIND_SITE = 3'd2,
    ACT_FIND_CRED = 3'd3,
    ACT_COUNT     = 3'd4,
    ACT_ERASE     = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    CMP_SITE = 2'd0,
    CMP_USER = 2'd1,
    CMP_CRED = 2'd2
  } cmp_sel_t;

  typedef struct packed {
    logic     accept;
    logic     load;
    logic     erase;
    logic     start;
    logic     write;
    logic     commit;
    logic     match_set;
    logic     match_drop;
    logic     best_clr;
    logic     best_try;
    logic     emit;
    cmp_sel_t cmp_sel;
  } rct_cmd_t;

  typedef struct packed {
    logic slot_valid;
    logic word_match;
    logic out_free;
  } rct_stat_t;

endpackage

@@ sv/rct_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_dp: datapath of the resident credential table
// Staging keys, key and stamp memories, valid bits, word compare, the newest
// stamp selector and the result register.
// ----------------------------------------------------------------------------
module rct_dp import rct_pkg::*; #(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int USER_ID_BYTES = USER_ID_BYTES_DEF,
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int UID_WORDS = (USER_ID_BYTES + 7) / 8,
  localparam int UW_W      = (UID_WORDS > 1) ? $clog2(UID_WORDS) : 1,
  localparam int WC_W      = $clog2(KEY_WORDS + UID_WORDS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_key_select,
  input  logic [2:0]        in_word_index,
  input  logic [63:0]       in_key_word,
  input  logic [6:0]        in_user_id_len,
  input  logic [31:0]       in_created_stamp,
  input  rct_cmd_t          cmd,
  input  logic [SLOT_W-1:0] slot,
  input  logic [WC_W-1:0]   wc,
  input  stat_t             res_status,
  input  logic [SLOT_W-1:0] res_slot,
  input  logic [4:0]        res_count,
  input  logic              res_last,
  output rct_stat_t         st,
  output logic [SLOT_W-1:0] best_slot,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [3:0]        out_slot_index,
  output logic [4:0]        out_found_count,
  output logic              out_last
);

  localparam int UW_P2 = 1 << UW_W;

  logic [63:0] site_stg_r [KEY_WORDS];
  logic [63:0] cred_stg_r [KEY_WORDS];
  logic [63:0] user_stg_r [UW_P2];

  logic [63:0] site_mem [SLOTS*KEY_WORDS];
  logic [63:0] cred_mem [SLOTS*KEY_WORDS];
  logic [63:0] user_mem [SLOTS*UW_P2];
  logic [31:0] stamp_mem [SLOTS];
  logic [6:0]  len_mem [SLOTS];

  logic [63:0] site_rd_r, cred_rd_r, user_rd_r;
  logic [31:0] stamp_rd_r;
  logic [6:0]  len_rd_r;

  logic [SLOTS-1:0] valid_r, match_r;
  logic [6:0]       len_r;
  logic [31:0]      stamp_r;
  logic             have_best_r;
  logic [31:0]      best_stamp_r;
  logic [SLOT_W-1:0] best_slot_r;

  logic             out_valid_r, out_last_r;
  logic [1:0]       out_status_r;
  logic [3:0]       out_slot_r;
  logic [4:0]       out_count_r;

  logic [6:0]      len_c;
  logic [WC_W-1:0] wc_m4;
  logic [UW_W-1:0] uw_rd;
  logic [1:0]      kw;
  logic [6:0]      ubase;
  logic [63:0]     umask;
  logic [5:0]      slot6;

  assign len_c = (in_user_id_len > 7'(USER_ID_BYTES)) ? 7'(USER_ID_BYTES) : in_user_id_len;
  assign wc_m4 = wc - WC_W'(KEY_WORDS);
  assign uw_rd = wc_m4[UW_W-1:0];
  assign kw    = wc[1:0];
  assign ubase = 7'(uw_rd) << 3;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      umask[b*8 +: 8] = (len_r > (ubase + 7'(b))) ? 8'hFF : 8'h00;
    end
  end

  // Staging keys.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        site_stg_r[i] <= '0;
        cred_stg_r[i] <= '0;
      end
      for (int i = 0; i < UW_P2; i++) begin
        user_stg_r[i] <= '0;
      end
    end else if (cmd.load) begin
      if (in_key_select == CMP_SITE && in_word_index < 3'(KEY_WORDS)) begin
        site_stg_r[in_word_index[1:0]] <= in_key_word;
      end else if (in_key_select == CMP_USER && {1'b0, in_word_index} < 4'(UID_WORDS)) begin
        user_stg_r[in_word_index[UW_W-1:0]] <= in_key_word;
      end else if (in_key_select == CMP_CRED && in_word_index < 3'(KEY_WORDS)) begin
        cred_stg_r[in_word_index[1:0]] <= in_key_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      len_r   <= len_c;
      stamp_r <= in_created_stamp;
    end
  end

  // Key memories.
  always_ff @(posedge clk) begin
    if (cmd.write && wc < WC_W'(KEY_WORDS)) begin
      site_mem[{slot, kw}] <= site_stg_r[kw];
      cred_mem[{slot, kw}] <= cred_stg_r[kw];
    end
    site_rd_r <= site_mem[{slot, kw}];
    cred_rd_r <= cred_mem[{slot, kw}];
  end

  always_ff @(posedge clk) begin
    if (cmd.write && wc < WC_W'(UID_WORDS)) begin
      user_mem[{slot, wc[UW_W-1:0]}] <= user_stg_r[wc[UW_W-1:0]];
    end
    user_rd_r <= user_mem[{slot, uw_rd}];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      stamp_mem[slot] <= stamp_r;
      len_mem[slot]   <= len_r;
    end
    stamp_rd_r <= stamp_mem[slot];
    len_rd_r   <= len_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.erase) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      valid_r[slot] <= 1'b1;
    end
  end

  always_comb begin
    case (cmd.cmp_sel)
      CMP_SITE: st.word_match = (site_rd_r == site_stg_r[kw]);
      CMP_USER: st.word_match = (len_rd_r == len_r) &&
                                (((user_rd_r ^ user_stg_r[uw_rd]) & umask) == '0);
      CMP_CRED: st.word_match = (cred_rd_r == cred_stg_r[kw]);
      default:  st.word_match = 1'b0;
    endcase
  end

  assign st.slot_valid = valid_r[slot];
  assign st.out_free   = !out_valid_r || !out_stall;

  // Matching slots and the newest-stamp pick over them.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      match_r <= '0;
    end else if (cmd.match_set) begin
      match_r[slot] <= 1'b1;
    end else if (cmd.match_drop) begin
      match_r[best_slot_r] <= 1'b0;
    end
    if (cmd.best_clr) begin
      have_best_r <= 1'b0;
    end else if (cmd.best_try && match_r[slot] &&
                 (!have_best_r || stamp_rd_r > best_stamp_r)) begin
      have_best_r  <= 1'b1;
      best_stamp_r <= stamp_rd_r;
      best_slot_r  <= slot;
    end
  end

  assign best_slot = best_slot_r;

  // Result register.
  assign slot6 = 6'(res_slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_status;
      out_slot_r   <= slot6[3:0];
      out_count_r  <= res_count;
      out_last_r   <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_slot_r;
  assign out_found_count = out_count_r;
  assign out_last        = out_last_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free) else $error("result issued over a pending one");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> valid_r[$past(slot)]) else $error("saved slot not marked valid");

  a_erase_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.erase |=> (valid_r == '0)) else $error("erase left a valid slot");

endmodule

@@ sv/rct_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_ctrl: controller of the resident credential table
// Walks the slots and key words for each request and sequences the results.
// ----------------------------------------------------------------------------
module rct_ctrl import rct_pkg::*; #(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int USER_ID_BYTES = USER_ID_BYTES_DEF,
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int UID_WORDS = (USER_ID_BYTES + 7) / 8,
  localparam int WC_W      = $clog2(KEY_WORDS + UID_WORDS + 1),
  localparam int CNT_W     = $clog2(SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_action,
  input  logic [4:0]        in_max_results_wanted,
  input  rct_stat_t         st,
  input  logic [SLOT_W-1:0] best_slot,
  output rct_cmd_t          cmd,
  output logic [SLOT_W-1:0] slot,
  output logic [WC_W-1:0]   wc,
  output stat_t             res_status,
  output logic [SLOT_W-1:0] res_slot,
  output logic [4:0]        res_count,
  output logic              res_last
);

  localparam int WMAX = (UID_WORDS > KEY_WORDS) ? UID_WORDS : KEY_WORDS;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_SLOT    = 10'b0000000010,
    S_RD      = 10'b0000000100,
    S_CMP     = 10'b0000001000,
    S_WRITE   = 10'b0000010000,
    S_SEL_RD  = 10'b0000100000,
    S_SEL_CMP = 10'b0001000000,
    S_SEL_END = 10'b0010000000,
    S_COUNT   = 10'b0100000000,
    S_EMIT    = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  act_t              op_r, op_nxt;
  logic [4:0]        want_r, want_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt, free_r, free_nxt;
  logic              have_free_r, have_free_nxt;
  logic [WC_W-1:0]   wc_r, wc_nxt, last_wc;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [4:0]        nout_r, nout_nxt, nlist_r, nlist_nxt;
  stat_t             rs_r, rs_nxt;
  logic [SLOT_W-1:0] rslot_r, rslot_nxt;
  logic [4:0]        rcnt_r, rcnt_nxt;
  logic              rlast_r, rlast_nxt;

  logic             last_slot, hit, scan_end, free_any;
  logic [SLOT_W-1:0] free_pick;
  logic [CNT_W-1:0] cnt_now;
  logic [6:0]       cnt7, want7;

  assign last_slot = (slot_r == SLOT_W'(SLOTS - 1));
  assign last_wc   = (op_r == ACT_SAVE) ? WC_W'(KEY_WORDS + UID_WORDS - 1)
                                        : WC_W'(KEY_WORDS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    want_r      <= want_nxt;
    slot_r      <= slot_nxt;
    free_r      <= free_nxt;
    have_free_r <= have_free_nxt;
    wc_r        <= wc_nxt;
    cnt_r       <= cnt_nxt;
    nout_r      <= nout_nxt;
    nlist_r     <= nlist_nxt;
    rs_r        <= rs_nxt;
    rslot_r     <= rslot_nxt;
    rcnt_r      <= rcnt_nxt;
    rlast_r     <= rlast_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    want_nxt      = want_r;
    slot_nxt      = slot_r;
    free_nxt      = free_r;
    have_free_nxt = have_free_r;
    wc_nxt        = wc_r;
    cnt_nxt       = cnt_r;
    nout_nxt      = nout_r;
    nlist_nxt     = nlist_r;
    rs_nxt        = rs_r;
    rslot_nxt     = rslot_r;
    rcnt_nxt      = rcnt_r;
    rlast_nxt     = rlast_r;
    cmd           = '0;
    hit           = 1'b0;
    scan_end      = 1'b0;
    free_any      = have_free_r;
    free_pick     = free_r;

    if (op_r == ACT_FIND_CRED) begin
      cmd.cmp_sel = CMP_CRED;
    end else if (op_r == ACT_SAVE && wc_r >= WC_W'(KEY_WORDS)) begin
      cmd.cmp_sel = CMP_USER;
    end else begin
      cmd.cmp_sel = CMP_SITE;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept    = 1'b1;
          op_nxt        = act_t'(in_action);
          want_nxt      = (in_max_results_wanted > 5'(RESULT_CAP)) ? 5'(RESULT_CAP)
                                                                 : in_max_results_wanted;
          slot_nxt      = '0;
          cnt_nxt       = '0;
          have_free_nxt = 1'b0;
          case (in_action) inside
            ACT_LOAD: cmd.load = 1'b1;
            ACT_SAVE, ACT_FIND_SITE, ACT_FIND_CRED: begin
              cmd.start = 1'b1;
              state_nxt = S_SLOT;
            end
            ACT_COUNT: state_nxt = S_COUNT;
            ACT_ERASE: begin
              cmd.erase = 1'b1;
              rs_nxt    = ST_OK;
              rslot_nxt = '0;
              rcnt_nxt  = '0;
              rlast_nxt = 1'b1;
              state_nxt = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_SLOT: begin
        if (st.slot_valid) begin
          wc_nxt    = '0;
          state_nxt = S_RD;
        end else begin
          if (!have_free_r) begin
            free_nxt      = slot_r;
            have_free_nxt = 1'b1;
            free_any      = 1'b1;
            free_pick     = slot_r;
          end
          scan_end = last_slot;
          if (!last_slot) begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if (st.word_match && wc_r != last_wc) begin
          wc_nxt    = wc_r + 1'b1;
          state_nxt = S_RD;
        end else if (st.word_match && op_r == ACT_SAVE) begin
          slot_nxt  = slot_r;
          wc_nxt    = '0;
          state_nxt = S_WRITE;
        end else if (st.word_match && op_r == ACT_FIND_CRED) begin
          rs_nxt    = ST_OK;
          rslot_nxt = slot_r;
          rcnt_nxt  = 5'd1;
          rlast_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          hit           = st.word_match;
          cmd.match_set = st.word_match;
          scan_end      = last_slot;
          if (!last_slot) begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = S_SLOT;
          end
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        if (wc_r == WC_W'(WMAX - 1)) begin
          cmd.commit = 1'b1;
          rs_nxt     = ST_OK;
          rslot_nxt  = slot_r;
          rcnt_nxt   = '0;
          rlast_nxt  = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          wc_nxt = wc_r + 1'b1;
        end
      end
      S_SEL_RD: state_nxt = S_SEL_CMP;
      S_SEL_CMP: begin
        cmd.best_try = 1'b1;
        if (last_slot) begin
          state_nxt = S_SEL_END;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = S_SEL_RD;
        end
      end
      S_SEL_END: begin
        cmd.match_drop = 1'b1;
        rs_nxt         = ST_OK;
        rslot_nxt      = best_slot;
        rcnt_nxt       = nlist_r;
        rlast_nxt      = (nout_r + 5'd1 == nlist_r);
        nout_nxt       = nout_r + 5'd1;
        state_nxt      = S_EMIT;
      end
      S_COUNT: begin
        cnt_nxt = cnt_r + CNT_W'(st.slot_valid);
        if (last_slot) begin
          rs_nxt    = ST_OK;
          rslot_nxt = '0;
          rcnt_nxt  = (7'(cnt_nxt) > 7'd31) ? 5'd31 : 5'(cnt_nxt);
          rlast_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (rlast_r) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.best_clr = 1'b1;
            slot_nxt     = '0;
            state_nxt    = S_SEL_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // End of a key scan over all slots.
    cnt_now = cnt_r + CNT_W'(hit);
    cnt7    = 7'(cnt_now);
    want7   = 7'(want_r);
    if (hit) begin
      cnt_nxt = cnt_now;
    end
    if (scan_end) begin
      rslot_nxt = '0;
      rcnt_nxt  = '0;
      rlast_nxt = 1'b1;
      state_nxt = S_EMIT;
      case (op_r)
        ACT_SAVE: begin
          if (free_any) begin
            slot_nxt  = free_pick;
            wc_nxt    = '0;
            state_nxt = S_WRITE;
          end else begin
            rs_nxt = ST_FULL;
          end
        end
        ACT_FIND_SITE: begin
          nlist_nxt = (cnt7 < want7) ? 5'(cnt7) : want_r;
          if (nlist_nxt == 5'd0) begin
            rs_nxt = ST_NOT_FOUND;
          end else begin
            nout_nxt     = '0;
            slot_nxt     = '0;
            cmd.best_clr = 1'b1;
            state_nxt    = S_SEL_RD;
          end
        end
        default: rs_nxt = ST_NOT_FOUND;
      endcase
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign slot       = slot_r;
  assign wc         = wc_r;
  assign res_status = rs_r;
  assign res_slot   = rslot_r;
  assign res_count  = rcnt_r;
  assign res_last   = rlast_r;

endmodule

@@ sv/resident_credential_table.sv @@
`timescale 1ns / 1ps
// A key word load gives no result. Save and find scan the slots in order and compare the
// stored words of each valid slot (4 per slot for site or credential, 4 + user id words
// for save); save and find by credential stop at a full match. Save then writes max(4, user
// id words) words to the matched or first free slot; find by site runs one more pass over
// all slots per listed slot. One request is in work at a time; the next is taken on return
// to idle, while the last result may still wait. Reset clears valid bits and staging.
// ----------------------------------------------------------------------------
// resident_credential_table: slot table of resident credential keys
// Stores site hash, user id and credential id per slot with a creation stamp
// and answers save, find by site, find by credential, count and erase.
// ----------------------------------------------------------------------------
module resident_credential_table import rct_pkg::*; #(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int USER_ID_BYTES = USER_ID_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [1:0]  in_key_select,
  input  logic [2:0]  in_word_index,
  input  logic [63:0] in_key_word,
  input  logic [6:0]  in_user_id_len,
  input  logic [31:0] in_created_stamp,
  input  logic [4:0]  in_max_results_wanted,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_index,
  output logic [4:0]  out_found_count,
  output logic        out_last
);

  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int UID_WORDS = (USER_ID_BYTES + 7) / 8;
  localparam int WC_W      = $clog2(KEY_WORDS + UID_WORDS + 1);

  // The controller owns the slot and word counters; the datapath owns every
  // stored key, the compare logic and the result register that decouples the
  // output side from the scan.
  rct_cmd_t          cmd;
  rct_stat_t         st;
  logic [SLOT_W-1:0] slot, best_slot, res_slot;
  logic [WC_W-1:0]   wc;
  stat_t             res_status;
  logic [4:0]        res_count;
  logic              res_last;

  rct_ctrl #(
    .SLOTS         (SLOTS),
    .USER_ID_BYTES (USER_ID_BYTES)
  ) u_ctrl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_action             (in_action),
    .in_max_results_wanted (in_max_results_wanted),
    .st                    (st),
    .best_slot             (best_slot),
    .cmd                   (cmd),
    .slot                  (slot),
    .wc                    (wc),
    .res_status            (res_status),
    .res_slot              (res_slot),
    .res_count             (res_count),
    .res_last              (res_last)
  );

  rct_dp #(
    .SLOTS         (SLOTS),
    .USER_ID_BYTES (USER_ID_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_key_select    (in_key_select),
    .in_word_index    (in_word_index),
    .in_key_word      (in_key_word),
    .in_user_id_len   (in_user_id_len),
    .in_created_stamp (in_created_stamp),
    .cmd              (cmd),
    .slot             (slot),
    .wc               (wc),
    .res_status       (res_status),
    .res_slot         (res_slot),
    .res_count        (res_count),
    .res_last         (res_last),
    .st               (st),
    .best_slot        (best_slot),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_found_count  (out_found_count),
    .out_last         (out_last)
  );

endmodule

@@ dv/resident_credential_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resident_credential_table_tb: self-checking bench of the credential table
// A short table of directed requests, then random load, save, lookup, count,
// erase and noise sequences go into the block. A bench model of the slot table
// predicts each result, and every returned result is compared field by field.
// ----------------------------------------------------------------------------
module resident_credential_table_tb;
  import rct_pkg::*;

  localparam int          SLOTS       = SLOTS_DEF;
  localparam int          UID_WORDS   = (USER_ID_BYTES_DEF + 7) / 8;
  localparam int          RANDOM_REQS = 360;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          DRAIN_WAIT  = 800;
  // Action and select codes the block leaves unused; they must change nothing.
  localparam logic [2:0]  ACT_SPARE_A = 3'd6;
  localparam logic [2:0]  ACT_SPARE_B = 3'd7;
  localparam logic [1:0]  SEL_SPARE   = 2'd3;
  localparam logic [63:0] ONES64      = '1;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  key_select;
    logic [2:0]  word_index;
    logic [63:0] key_word;
    logic [6:0]  user_id_len;
    logic [31:0] created_stamp;
    logic [4:0]  max_wanted;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_index;
    logic [4:0] found_count;
    logic       last;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [1:0]  in_key_select = '0;
  logic [2:0]  in_word_index = '0;
  logic [63:0] in_key_word = '0;
  logic [6:0]  in_user_id_len = '0;
  logic [31:0] in_created_stamp = '0;
  logic [4:0]  in_max_results_wanted = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_slot_index;
  logic [4:0]  out_found_count;
  logic        out_last;

  always #6 clk = ~clk;

  resident_credential_table dut (.*);

  // Stimulus: every request, with an optional hand-written answer for the
  // directed rows whose result is obvious.
  request_t stimulus_q[$];
  bit       typed_q[$];
  answer_t  typed_ans_q[$];
  int       next_req = 0;

  // Answers still owed by the block, oldest first.
  answer_t  owed_answers[$];
  answer_t  fresh[$];
  int       errors = 0;
  int       cycles = 0;

  // Shadow copy of the table.
  bit          shadow_valid[SLOTS];
  logic [63:0] shadow_site[SLOTS][KEY_WORDS];
  logic [63:0] shadow_cred[SLOTS][KEY_WORDS];
  logic [63:0] shadow_user[SLOTS][UID_WORDS];
  logic [6:0]  shadow_ulen[SLOTS];
  logic [31:0] shadow_stamp[SLOTS];
  logic [63:0] staged_site[KEY_WORDS];
  logic [63:0] staged_cred[KEY_WORDS];
  logic [63:0] staged_user[UID_WORDS];

  // Pools of keys so that random sequences hit stored slots again.
  logic [63:0] site_pool[4][KEY_WORDS];
  logic [63:0] cred_pool[4][KEY_WORDS];
  logic [63:0] user_pool[6][UID_WORDS];
  logic [6:0]  ulen_pool[6];

  function automatic void add_req(logic [2:0] act, logic [1:0] sel, logic [2:0] widx,
                                  logic [63:0] word, logic [6:0] len, logic [31:0] stamp,
                                  logic [4:0] want);
    request_t r;
    r = '{act, sel, widx, word, len, stamp, want};
    stimulus_q.push_back(r);
    typed_q.push_back(1'b0);
    typed_ans_q.push_back('0);
  endfunction

  // Same as add_req, but the answer is written down by hand.
  function automatic void add_typed(logic [2:0] act, logic [6:0] len, logic [31:0] stamp,
                                    logic [4:0] want, stat_t st, logic [3:0] slot,
                                    logic [4:0] cnt);
    add_req(act, '0, '0, '0, len, stamp, want);
    typed_q[$] = 1'b1;
    typed_ans_q[$] = '{st, slot, cnt, 1'b1};
  endfunction

  function automatic void load_key(cmp_sel_t sel, int words, logic [63:0] vals[]);
    for (int w = 0; w < words; w++)
      add_req(ACT_LOAD, sel, w[2:0], vals[w], '0, '0, '0);
  endfunction

  function automatic bit site_matches(int s);
    for (int w = 0; w < KEY_WORDS; w++)
      if (shadow_site[s][w] !== staged_site[w]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit cred_matches(int s);
    for (int w = 0; w < KEY_WORDS; w++)
      if (shadow_cred[s][w] !== staged_cred[w]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit user_matches(int s, int len);
    int          have;
    logic [63:0] mask;
    if (shadow_ulen[s] != len) return 1'b0;
    for (int w = 0; w < UID_WORDS; w++) begin
      have = len - w * 8;
      if (have <= 0) break;
      mask = (have >= 8) ? ONES64 : ((64'd1 << (8 * have)) - 64'd1);
      if (((shadow_user[s][w] ^ staged_user[w]) & mask) != '0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the answers of one accepted request into fresh and updates the
  // shadow table.
  function automatic void table_predict(request_t r);
    int len, want, target, n, cur, j, count;
    int order[SLOTS];
    bit hit;
    fresh.delete();
    len = (r.user_id_len > USER_ID_BYTES_DEF) ? USER_ID_BYTES_DEF : r.user_id_len;
    want = (r.max_wanted > RESULT_CAP) ? RESULT_CAP : r.max_wanted;
    case (r.action)
      ACT_LOAD: begin
        if (r.key_select == CMP_SITE && r.word_index < KEY_WORDS)
          staged_site[r.word_index] = r.key_word;
        else if (r.key_select == CMP_USER && r.word_index < UID_WORDS)
          staged_user[r.word_index] = r.key_word;
        else if (r.key_select == CMP_CRED && r.word_index < KEY_WORDS)
          staged_cred[r.word_index] = r.key_word;
      end
      ACT_SAVE: begin
        target = -1;
        for (int s = 0; s < SLOTS && target < 0; s++)
          if (shadow_valid[s] && site_matches(s) && user_matches(s, len)) target = s;
        for (int s = 0; s < SLOTS && target < 0; s++)
          if (!shadow_valid[s]) target = s;
        if (target < 0) begin
          fresh.push_back('{ST_FULL, 4'd0, 5'd0, 1'b1});
        end else begin
          shadow_site[target] = staged_site;
          shadow_cred[target] = staged_cred;
          shadow_user[target] = staged_user;
          shadow_ulen[target] = len[6:0];
          shadow_stamp[target] = r.created_stamp;
          shadow_valid[target] = 1'b1;
          fresh.push_back('{ST_OK, target[3:0], 5'd0, 1'b1});
        end
      end
      ACT_FIND_SITE: begin
        n = 0;
        for (int s = 0; s < SLOTS; s++)
          if (shadow_valid[s] && site_matches(s)) begin
            order[n] = s;
            n++;
          end
        // Stable insertion: newest stamp first, ties keep slot order.
        for (int k = 1; k < n; k++) begin
          cur = order[k];
          j = k;
          while (j > 0 && shadow_stamp[order[j-1]] < shadow_stamp[cur]) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = cur;
        end
        if (n > want) n = want;
        if (n == 0) fresh.push_back('{ST_NOT_FOUND, 4'd0, 5'd0, 1'b1});
        for (int k = 0; k < n; k++)
          fresh.push_back('{ST_OK, order[k][3:0], n[4:0], (k + 1 == n)});
      end
      ACT_FIND_CRED: begin
        hit = 1'b0;
        for (int s = 0; s < SLOTS && !hit; s++)
          if (shadow_valid[s] && cred_matches(s)) begin
            hit = 1'b1;
            fresh.push_back('{ST_OK, s[3:0], 5'd1, 1'b1});
          end
        if (!hit) fresh.push_back('{ST_NOT_FOUND, 4'd0, 5'd0, 1'b1});
      end
      ACT_COUNT: begin
        count = 0;
        for (int s = 0; s < SLOTS; s++) count += shadow_valid[s];
        if (count > 31) count = 31;
        fresh.push_back('{ST_OK, 4'd0, count[4:0], 1'b1});
      end
      ACT_ERASE: begin
        for (int s = 0; s < SLOTS; s++) shadow_valid[s] = 1'b0;
        fresh.push_back('{ST_OK, 4'd0, 5'd0, 1'b1});
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, answer_t got, answer_t want);
    $display("t=%0t mismatch (%s): got st=%0d slot=%0d cnt=%0d last=%0d, ", $realtime, what,
             got.status, got.slot_index, got.found_count, got.last,
             "want st=%0d slot=%0d cnt=%0d last=%0d",
             want.status, want.slot_index, want.found_count, want.last);
    errors++;
  endtask

  // Builds one random sequence of requests; returns how many of them count.
  function automatic int add_random_sequence();
    int          pick, u, sidx;
    logic [63:0] words[];
    logic [6:0]  len;
    pick = $urandom_range(99);
    sidx = $urandom_range(3);
    words = new[UID_WORDS];
    if (pick < 45) begin
      // Save: stage all three keys, then store them.
      for (int w = 0; w < KEY_WORDS; w++) words[w] = site_pool[sidx][w];
      load_key(CMP_SITE, KEY_WORDS, words);
      u = $urandom_range(5);
      for (int w = 0; w < UID_WORDS; w++) words[w] = user_pool[u][w];
      if ($urandom_range(9) == 0) words[$urandom_range(UID_WORDS - 1)] = {$urandom, $urandom};
      load_key(CMP_USER, $urandom_range(3) == 0 ? $urandom_range(UID_WORDS) : UID_WORDS,
               words);
      for (int w = 0; w < KEY_WORDS; w++) words[w] = cred_pool[$urandom_range(3)][w];
      load_key(CMP_CRED, KEY_WORDS, words);
      len = ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : ulen_pool[u];
      add_req(ACT_SAVE, '0, '0, '0, len,
              $urandom_range(1) ? 32'($urandom_range(7)) : 32'($urandom), '0);
      return 1 + KEY_WORDS * 2 + UID_WORDS;
    end else if (pick < 65) begin
      if ($urandom_range(3) != 0) begin
        for (int w = 0; w < KEY_WORDS; w++) words[w] = site_pool[sidx][w];
        load_key(CMP_SITE, KEY_WORDS, words);
      end
      add_req(ACT_FIND_SITE, '0, '0, '0, '0, '0,
              $urandom_range(5) == 0 ? 5'($urandom_range(31)) : 5'($urandom_range(16)));
      return 1;
    end else if (pick < 78) begin
      for (int w = 0; w < KEY_WORDS; w++) words[w] = cred_pool[sidx][w];
      load_key(CMP_CRED, KEY_WORDS, words);
      add_req(ACT_FIND_CRED, '0, '0, '0, '0, '0, '0);
      return 1;
    end else if (pick < 85) begin
      add_req(ACT_COUNT, '0, '0, '0, '0, '0, '0);
      return 1;
    end else if (pick < 88) begin
      add_req(ACT_ERASE, '0, '0, '0, '0, '0, '0);
      return 1;
    end
    // Noise: any action code with every field random.
    add_req(3'($urandom_range(7)), 2'($urandom_range(3)), 3'($urandom_range(7)),
            {$urandom, $urandom}, 7'($urandom_range(127)), $urandom,
            5'($urandom_range(31)));
    return 1;
  endfunction

  // Directed rows first, then random sequences.
  initial begin
    logic [63:0] words[];
    int          made;
    words = new[UID_WORDS];
    // The staging keys come out of reset as zero.
    for (int w = 0; w < KEY_WORDS; w++) begin
      staged_site[w] = '0;
      staged_cred[w] = '0;
    end
    for (int w = 0; w < UID_WORDS; w++) staged_user[w] = '0;
    for (int k = 0; k < 4; k++)
      for (int w = 0; w < KEY_WORDS; w++) begin
        site_pool[k][w] = {$urandom, $urandom};
        cred_pool[k][w] = {$urandom, $urandom};
      end
    for (int u = 0; u < 6; u++) begin
      for (int w = 0; w < UID_WORDS; w++) user_pool[u][w] = {$urandom, $urandom};
      ulen_pool[u] = 7'($urandom_range(64));
    end
    // An empty table answers count, lookups and erase plainly.
    add_typed(ACT_COUNT, '0, '0, '0, ST_OK, 4'd0, 5'd0);
    add_typed(ACT_FIND_SITE, '0, '0, 5'd16, ST_NOT_FOUND, 4'd0, 5'd0);
    add_typed(ACT_FIND_CRED, '0, '0, '0, ST_NOT_FOUND, 4'd0, 5'd0);
    add_typed(ACT_ERASE, '0, '0, '0, ST_OK, 4'd0, 5'd0);
    // All-ones site hash and first user word, overlong user id length.
    for (int w = 0; w < UID_WORDS; w++) words[w] = ONES64;
    load_key(CMP_SITE, KEY_WORDS, words);
    load_key(CMP_USER, 1, words);
    add_typed(ACT_SAVE, 7'd127, '1, '0, ST_OK, 4'd0, 5'd0);
    // The same site and user overwrite the same slot.
    add_typed(ACT_SAVE, 7'd64, 32'd5, '0, ST_OK, 4'd0, 5'd0);
    // A change in the last user word makes a new user.
    add_req(ACT_LOAD, CMP_USER, 3'd7, 64'd1, '0, '0, '0);
    add_typed(ACT_SAVE, 7'd64, 32'd5, '0, ST_OK, 4'd1, 5'd0);
    add_req(ACT_FIND_SITE, '0, '0, '0, '0, '0, 5'd31);
    add_typed(ACT_FIND_SITE, '0, '0, 5'd0, ST_NOT_FOUND, 4'd0, 5'd0);
    // Loads outside the staging keys are ignored.
    add_req(ACT_LOAD, SEL_SPARE, 3'd7, ONES64, '0, '0, '0);
    add_req(ACT_LOAD, CMP_SITE, 3'd4, '0, '0, '0, '0);
    add_req(ACT_LOAD, CMP_CRED, 3'd7, '0, '0, '0, '0);
    add_req(ACT_SPARE_A, CMP_USER, '0, '0, '0, '0, '0);
    add_req(ACT_SPARE_B, CMP_USER, '0, '0, '0, '0, '0);
    add_req(ACT_FIND_CRED, '0, '0, '0, '0, '0, '0);
    // Zero-length user id with the oldest stamp.
    add_req(ACT_SAVE, '0, '0, '0, 7'd0, 32'd0, '0);
    add_req(ACT_FIND_SITE, '0, '0, '0, '0, '0, 5'd17);
    add_req(ACT_COUNT, '0, '0, '0, '0, '0, '0);
    made = 0;
    while (made < RANDOM_REQS) made += add_random_sequence();
  end

  // Request driver: the sender idles 23 in 100, then 51, then never.
  always @(posedge clk) begin
    int idle_pct;
    request_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        table_predict(stimulus_q[next_req]);
        if (typed_q[next_req]) owed_answers.push_back(typed_ans_q[next_req]);
        else foreach (fresh[k]) owed_answers.push_back(fresh[k]);
        next_req++;
      end
      idle_pct = (next_req < stimulus_q.size() / 3) ? 23 :
                 (next_req < 2 * stimulus_q.size() / 3) ? 51 : 0;
      if (in_valid && in_stall) begin
        // Hold the stalled request as it is.
      end else if (next_req < stimulus_q.size() && $urandom_range(99) >= idle_pct) begin
        r = stimulus_q[next_req];
        in_valid <= 1'b1;
        in_action <= r.action;
        in_key_select <= r.key_select;
        in_word_index <= r.word_index;
        in_key_word <= r.key_word;
        in_user_id_len <= r.user_id_len;
        in_created_stamp <= r.created_stamp;
        in_max_results_wanted <= r.max_wanted;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: the receiver stalls 51 in 100, then 23, then never.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    int stall_pct;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_status, out_slot_index, out_found_count, out_last};
        if (owed_answers.size() == 0) begin
          report_mismatch("nothing expected", got, '0);
        end else begin
          want = owed_answers.pop_front();
          if (got.status !== want.status) report_mismatch("status", got, want);
          if (got.slot_index !== want.slot_index) report_mismatch("slot", got, want);
          if (got.found_count !== want.found_count) report_mismatch("count", got, want);
          if (got.last !== want.last) report_mismatch("last", got, want);
        end
      end
      stall_pct = (next_req < stimulus_q.size() / 3) ? 51 :
                  (next_req < 2 * stimulus_q.size() / 3) ? 23 : 0;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Run control: one reset, then wait for the stimulus to drain.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_q.size() > 0 && next_req == stimulus_q.size());
    wait (owed_answers.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && owed_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
